### design/rdcmle_pkg.sv
// Shared types, constants and helpers for the constrained risk-difference estimator.
package rdcmle_pkg;

    localparam int FRACTION_BITS      = 30;
    localparam int COUNT_BITS         = 16;
    localparam int ITERATIONS_DEFAULT = 32;

    // Signed working width for rates, bounds and the difference.
    localparam int RATE_BITS   = 34;
    localparam int OUT_BITS    = 31;
    localparam int PROD_BITS   = COUNT_BITS + FRACTION_BITS;
    localparam int DIFF_BITS   = PROD_BITS + 2;
    localparam int DIGIT_BITS  = 15;
    localparam int CELLS       = 4;
    localparam int WEIGHT_BITS = DIGIT_BITS * CELLS;
    localparam int PART_BITS   = DIFF_BITS + DIGIT_BITS + 2;
    localparam int ACC_BITS    = 108;

    localparam logic signed [RATE_BITS-1:0] ONE = RATE_BITS'(64'sd1 <<< FRACTION_BITS);

    typedef struct packed {
        logic [15:0]        treated_successes;
        logic [15:0]        treated_trials;
        logic [15:0]        control_successes;
        logic [15:0]        control_trials;
        logic signed [31:0] rate_difference;
    } item_in_t;

    typedef struct packed {
        logic [30:0] control_rate;
        logic [30:0] treated_rate;
        logic        degenerate;
    } item_out_t;

    // Operands broadcast to every cell of the score chain.
    typedef struct packed {
        logic signed [DIFF_BITS-1:0] treated_diff;
        logic signed [DIFF_BITS-1:0] control_diff;
        logic [WEIGHT_BITS-1:0]      treated_weight;
        logic [WEIGHT_BITS-1:0]      control_weight;
    } cell_op_t;

    function automatic logic [OUT_BITS-1:0] clamp_rate(input logic signed [RATE_BITS-1:0] v);
        logic [OUT_BITS-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > ONE)
            r = ONE[OUT_BITS-1:0];
        else
            r = v[OUT_BITS-1:0];
        return r;
    endfunction

endpackage

### design/risk_difference_constrained_mle.sv
// Top level: constrained control-rate bisection with a chained score multiplier.
// A degenerate item goes straight to the finish step; otherwise each bisection step
//   runs probe, multiply, difference, cell chain and decide, for up to ITERATIONS steps.
//   A probe at a boundary skips the multiply; an exactly zero score ends the search early.
// Throughput: one item at a time, set by the multiply and cell-chain pass of each step.
// Reset: rst_n clears the sequencer and the result valid; no clearing pass.
module risk_difference_constrained_mle #(
    parameter int ITERATIONS = rdcmle_pkg::ITERATIONS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  rdcmle_pkg::item_in_t  item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output rdcmle_pkg::item_out_t result
);
    import rdcmle_pkg::*;

    localparam int ITER_BITS = $clog2(ITERATIONS + 1);
    localparam int WAIT_BITS = $clog2(CELLS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_MULT,
        S_DIFF,
        S_CHAIN,
        S_DECIDE,
        S_FINISH
    } state_t;

    state_t state_reg;

    logic [COUNT_BITS-1:0]      xt_reg, nt_reg, xc_reg, nc_reg;
    logic signed [RATE_BITS-1:0] delta_reg;
    logic signed [RATE_BITS-1:0] low_reg, up_reg, mid_reg;
    logic [FRACTION_BITS-1:0]   pc_reg, pt_reg;
    logic [ITER_BITS-1:0]       iter_reg;
    logic [WAIT_BITS-1:0]       wait_reg;
    logic                       degen_reg;
    logic [PROD_BITS-1:0]       tprod_reg, cprod_reg;
    logic [WEIGHT_BITS-1:0]     cweight_reg, tweight_reg;
    cell_op_t                   op_reg;
    logic                       result_valid_reg;
    item_out_t                  result_reg;

    // Input decode
    logic [COUNT_BITS-1:0]       in_xt, in_xc;
    logic signed [RATE_BITS-1:0] in_delta;
    logic                        in_degen;

    // Probe
    logic signed [RATE_BITS-1:0] mid;
    logic signed [RATE_BITS-1:0] pt_probe;
    logic                        probe_pos, probe_neg;

    // Multiply and difference operands
    logic [FRACTION_BITS:0]      pc_comp, pt_comp;

    // Chain
    logic signed [ACC_BITS-1:0]  acc [CELLS+1];
    logic signed [ACC_BITS-1:0]  score;

    // Clamp success counts to their trial counts.
    assign in_xt    = (item.treated_successes > item.treated_trials)
                    ? item.treated_trials : item.treated_successes;
    assign in_xc    = (item.control_successes > item.control_trials)
                    ? item.control_trials : item.control_successes;
    assign in_delta = RATE_BITS'(item.rate_difference);
    assign in_degen = (in_delta >= ONE) || (in_delta <= -ONE);

    assign mid       = (low_reg + up_reg) >>> 1;
    assign pt_probe  = mid + delta_reg;
    // A rate at or past zero counts as a positive score, at or past one as negative.
    assign probe_pos = (mid <= 0) || (pt_probe <= 0);
    assign probe_neg = (mid >= ONE) || (pt_probe >= ONE);

    assign pc_comp = ONE[FRACTION_BITS:0] - {1'b0, pc_reg};
    assign pt_comp = ONE[FRACTION_BITS:0] - {1'b0, pt_reg};

    // Score chain: most significant digit first, partial sums flow toward cell 0.
    assign acc[CELLS] = '0;

    genvar g;
    generate
        for (g = 0; g < CELLS; g++)
        begin : g_cell
            rdcmle_cell #(
                .DIGIT (g)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .op      (op_reg),
                .acc_in  (acc[g+1]),
                .acc_out (acc[g])
            );
        end
    endgenerate

    assign score = acc[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            xt_reg           <= '0;
            nt_reg           <= '0;
            xc_reg           <= '0;
            nc_reg           <= '0;
            delta_reg        <= '0;
            low_reg          <= '0;
            up_reg           <= '0;
            mid_reg          <= '0;
            pc_reg           <= '0;
            pt_reg           <= '0;
            iter_reg         <= '0;
            wait_reg         <= '0;
            degen_reg        <= 1'b0;
            tprod_reg        <= '0;
            cprod_reg        <= '0;
            cweight_reg      <= '0;
            tweight_reg      <= '0;
            op_reg           <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            // Drop the result once the downstream side takes it; the finish step
            // reloads it on its own.
            if (result_valid_reg && !result_stall && (state_reg != S_FINISH))
                result_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        xt_reg    <= in_xt;
                        nt_reg    <= item.treated_trials;
                        xc_reg    <= in_xc;
                        nc_reg    <= item.control_trials;
                        delta_reg <= in_delta;
                        degen_reg <= in_degen;
                        iter_reg  <= '0;
                        // Search interval kept one unit inside both ends.
                        low_reg   <= ((in_delta < 0) ? -in_delta : RATE_BITS'(0)) + 1;
                        up_reg    <= ((in_delta > 0) ? ONE - in_delta : ONE) - 1;
                        // Empty interval: land on the end that clamps to the answer.
                        mid_reg   <= (in_delta > 0) ? RATE_BITS'(0) : ONE;
                        state_reg <= in_degen ? S_FINISH : S_PROBE;
                    end
                end

                S_PROBE:
                begin
                    if (iter_reg == ITER_BITS'(ITERATIONS))
                    begin
                        mid_reg   <= mid;
                        state_reg <= S_FINISH;
                    end
                    else if (probe_pos)
                    begin
                        low_reg  <= mid;
                        iter_reg <= iter_reg + 1'b1;
                    end
                    else if (probe_neg)
                    begin
                        up_reg   <= mid;
                        iter_reg <= iter_reg + 1'b1;
                    end
                    else
                    begin
                        mid_reg   <= mid;
                        pc_reg    <= mid[FRACTION_BITS-1:0];
                        pt_reg    <= pt_probe[FRACTION_BITS-1:0];
                        state_reg <= S_MULT;
                    end
                end

                S_MULT:
                begin
                    tprod_reg   <= nt_reg * pt_reg;
                    cprod_reg   <= nc_reg * pc_reg;
                    cweight_reg <= WEIGHT_BITS'(pc_reg * pc_comp);
                    tweight_reg <= WEIGHT_BITS'(pt_reg * pt_comp);
                    state_reg   <= S_DIFF;
                end

                S_DIFF:
                begin
                    op_reg.treated_diff   <= $signed({2'b00, xt_reg, {FRACTION_BITS{1'b0}}})
                                           - $signed({2'b00, tprod_reg});
                    op_reg.control_diff   <= $signed({2'b00, xc_reg, {FRACTION_BITS{1'b0}}})
                                           - $signed({2'b00, cprod_reg});
                    op_reg.treated_weight <= tweight_reg;
                    op_reg.control_weight <= cweight_reg;
                    wait_reg              <= '0;
                    state_reg             <= S_CHAIN;
                end

                S_CHAIN:
                begin
                    // Hold until the sum has passed through every cell.
                    if (wait_reg == WAIT_BITS'(CELLS))
                        state_reg <= S_DECIDE;
                    else
                        wait_reg <= wait_reg + 1'b1;
                end

                S_DECIDE:
                begin
                    if (score == 0)
                        state_reg <= S_FINISH;
                    else
                    begin
                        if (score > 0)
                            low_reg <= mid_reg;
                        else
                            up_reg <= mid_reg;
                        iter_reg  <= iter_reg + 1'b1;
                        state_reg <= S_PROBE;
                    end
                end

                S_FINISH:
                begin
                    if (!result_valid_reg || !result_stall)
                    begin
                        result_reg.control_rate <= clamp_rate(mid_reg);
                        result_reg.treated_rate <= clamp_rate(mid_reg + delta_reg);
                        result_reg.degenerate   <= degen_reg;
                        result_valid_reg        <= 1'b1;
                        state_reg               <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### design/rdcmle_cell.sv
// One cell of the score chain: a digit partial product folded into the running sum.
module rdcmle_cell #(
    parameter int DIGIT = 0
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  rdcmle_pkg::cell_op_t                  op,
    input  logic signed [rdcmle_pkg::ACC_BITS-1:0] acc_in,
    output logic signed [rdcmle_pkg::ACC_BITS-1:0] acc_out
);
    import rdcmle_pkg::*;

    logic [DIGIT_BITS-1:0]       t_digit;
    logic [DIGIT_BITS-1:0]       c_digit;
    logic signed [PART_BITS-1:0] part_next;
    logic signed [PART_BITS-1:0] part_reg;
    logic signed [ACC_BITS-1:0]  acc_next;
    logic signed [ACC_BITS-1:0]  acc_reg;

    // Treated difference pairs with the control weight and vice versa.
    assign t_digit = op.control_weight[DIGIT*DIGIT_BITS +: DIGIT_BITS];
    assign c_digit = op.treated_weight[DIGIT*DIGIT_BITS +: DIGIT_BITS];

    assign part_next = PART_BITS'(op.treated_diff * $signed({1'b0, t_digit}))
                     + PART_BITS'(op.control_diff * $signed({1'b0, c_digit}));

    // Shift the upper digits' sum up one digit and add this digit's part.
    assign acc_next = (acc_in <<< DIGIT_BITS) + ACC_BITS'(part_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            part_reg <= part_next;
            acc_reg  <= acc_next;
        end
    end

    assign acc_out = acc_reg;

endmodule
